>>> rtl/core/tlbpt_pkg.sv
// tlbpt_pkg: sizes, link and control structs and sequencer states of the tlb translator
// no dependencies; imported by every module under rtl/core
package tlbpt_pkg;

	localparam int NUM_PAGES   = 256;
	localparam int TLB_ENTRIES = 16;
	localparam int OFFSET_BITS = 8;
	localparam int VA_W        = 16;
	localparam int CNT_W       = 32;
	localparam int PAGE_W      = $clog2(NUM_PAGES);
	localparam int FRAME_W     = PAGE_W;
	localparam int REC_W       = $clog2(TLB_ENTRIES);
	localparam logic [REC_W-1:0] REC_OLDEST = REC_W'(TLB_ENTRIES - 1);

	// value passed from one tlb cell to the next
	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic [REC_W-1:0]   age;
	} tlbpt_link_t;

	// broadcast to every tlb cell
	typedef struct packed {
		logic               commit;
		logic               hit;
		logic [REC_W-1:0]   age;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} tlbpt_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} tlbpt_state_t;

endpackage

>>> rtl/core/tlbpt_cell.sv
// tlbpt_cell: one tlb entry with tag compare, lru rank and chained hit/frame/age result
// depends on tlbpt_pkg
module tlbpt_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tlbpt_pkg::tlbpt_ctl_t  ctl,
	input  logic                   prev_valid,
	output logic                   valid,
	input  tlbpt_pkg::tlbpt_link_t link_in,
	output tlbpt_pkg::tlbpt_link_t link_out
);
	import tlbpt_pkg::*;

	logic               valid_q;
	logic [PAGE_W-1:0]  tag_q;
	logic [FRAME_W-1:0] frame_q;
	logic [REC_W-1:0]   rec_q;
	logic               match;
	logic               victim;

	assign valid  = valid_q;
	assign match  = valid_q && (tag_q == ctl.page);
	// first empty slot, or the oldest valid entry once the row is full
	assign victim = valid_q ? (rec_q == REC_OLDEST) : prev_valid;

	always_comb begin
		link_out.hit   = link_in.hit | match;
		link_out.frame = link_in.frame | (match ? frame_q : '0);
		link_out.age   = link_in.age | (match ? rec_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rec_q   <= '0;
		end else if (ctl.commit) begin
			if (ctl.hit) begin
				if (match) begin
					rec_q <= '0;
				end else if (valid_q && rec_q < ctl.age) begin
					rec_q <= rec_q + 1'b1;
				end
			end else if (victim) begin
				valid_q <= 1'b1;
				rec_q   <= '0;
			end else if (valid_q) begin
				rec_q <= rec_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit && !ctl.hit && victim) begin
			tag_q   <= ctl.page;
			frame_q <= ctl.frame;
		end
	end

endmodule

>>> rtl/core/tlbpt_page_table.sv
// tlbpt_page_table: page map memory with registered read and per-page valid flops
// depends on tlbpt_pkg
module tlbpt_page_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [tlbpt_pkg::PAGE_W-1:0] rd_page,
	output logic [tlbpt_pkg::FRAME_W-1:0] rd_frame,
	output logic                         rd_valid,
	input  logic                         wr_en,
	input  logic [tlbpt_pkg::PAGE_W-1:0] wr_page,
	input  logic [tlbpt_pkg::FRAME_W-1:0] wr_frame
);
	import tlbpt_pkg::*;

	logic [FRAME_W-1:0]   map_mem [NUM_PAGES];
	logic [NUM_PAGES-1:0] map_valid_q;
	logic [FRAME_W-1:0]   rd_frame_q;
	logic                 rd_valid_q;

	assign rd_frame = rd_frame_q;
	assign rd_valid = rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_page] <= wr_frame;
		end
		if (rd_en) begin
			rd_frame_q <= map_mem[rd_page];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				map_valid_q[wr_page] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= map_valid_q[rd_page];
			end
		end
	end

endmodule

>>> rtl/core/tlb_page_table_translator.sv
// tlb_page_table_translator: virtual to physical translation, 16-entry lru tlb plus page table
// depends on tlbpt_pkg, tlbpt_cell and tlbpt_page_table
//
// usage: drive virtual_address with start while busy is low; that beat is taken.
// the page table is read in the accept cycle; in the next cycle (busy high) the row of
// tlb cells compares the page, a miss refills the first empty or least recently used
// cell, and a page fault takes the next free frame and writes the page table.
// the result beat (phys_addr, tlb_hit, page_fault and the three running totals)
// shows on the outputs with done high for exactly one cycle, registered from the compare.
// a new address is taken only while busy is low: the registered page table read is
// followed by the compare and update cycle of the cell row.
// the receiver cannot stall; a new beat may be taken in the same cycle done is high.
// reset: the tlb and page table are all invalid, the free frame counter and totals are zero.
module tlb_page_table_translator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tlbpt_pkg::VA_W-1:0]  virtual_address,
	output logic                        done,
	output logic [tlbpt_pkg::VA_W-1:0]  phys_addr,
	output logic                        tlb_hit,
	output logic                        page_fault,
	output logic [tlbpt_pkg::CNT_W-1:0] hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0] fault_total,
	output logic [tlbpt_pkg::CNT_W-1:0] address_total
);
	import tlbpt_pkg::*;

	tlbpt_state_t       state_q, state_d;
	logic               accept;
	logic [VA_W-1:0]    va_q;
	logic [PAGE_W-1:0]  page;
	logic [FRAME_W-1:0] pt_frame;
	logic               pt_valid;
	logic [FRAME_W-1:0] free_q;
	logic               hit;
	logic               fault;
	logic               commit;
	logic [FRAME_W-1:0] frame;
	tlbpt_ctl_t         ctl;
	tlbpt_link_t        links [TLB_ENTRIES+1];
	logic               vchain [TLB_ENTRIES+1];
	logic               done_q;
	logic [VA_W-1:0]    pa_q;
	logic               hit_q;
	logic               fault_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic [CNT_W-1:0]   fault_cnt_q;
	logic [CNT_W-1:0]   addr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				busy    = 1'b1;
				commit  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			va_q <= virtual_address;
		end
	end

	tlbpt_page_table u_page_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_page  (virtual_address[OFFSET_BITS +: PAGE_W]),
		.rd_frame (pt_frame),
		.rd_valid (pt_valid),
		.wr_en    (commit && fault),
		.wr_page  (page),
		.wr_frame (free_q)
	);

	assign page  = va_q[OFFSET_BITS +: PAGE_W];
	assign hit   = links[TLB_ENTRIES].hit;
	assign fault = !hit && !pt_valid;
	assign frame = hit ? links[TLB_ENTRIES].frame : (pt_valid ? pt_frame : free_q);

	always_comb begin
		ctl.commit = commit;
		ctl.hit    = hit;
		ctl.age    = links[TLB_ENTRIES].age;
		ctl.page   = page;
		ctl.frame  = frame;
	end

	assign links[0]  = '0;
	assign vchain[0] = 1'b1;

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		tlbpt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_valid (vchain[i]),
			.valid      (vchain[i+1]),
			.link_in    (links[i]),
			.link_out   (links[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			addr_cnt_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= commit;
			if (commit) begin
				if (fault) begin
					free_q <= free_q + 1'b1;
					if (fault_cnt_q != '1) begin
						fault_cnt_q <= fault_cnt_q + 1'b1;
					end
				end
				if (hit && hit_cnt_q != '1) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end
				if (addr_cnt_q != '1) begin
					addr_cnt_q <= addr_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pa_q    <= VA_W'({frame, va_q[OFFSET_BITS-1:0]});
			hit_q   <= hit;
			fault_q <= fault;
		end
	end

	assign done          = done_q;
	assign phys_addr     = pa_q;
	assign tlb_hit       = hit_q;
	assign page_fault    = fault_q;
	assign hit_total     = hit_cnt_q;
	assign fault_total   = fault_cnt_q;
	assign address_total = addr_cnt_q;

endmodule
